FILE: design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with active-low reset disable
`define DLH_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("dlh checker: property failed");

// condition that must never be seen
`define DLH_ASSERT_NEVER(lbl, ck, rn, cond) `DLH_ASSERT(lbl, ck, rn, !(cond))

`endif

FILE: design/dlh_pkg.sv
// ----------------------------------------------------------------------------
// dlh_pkg
// Shared types and codes of the line hull table: stored line record, cell
// shift controls, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package dlh_pkg;

  // result status codes
  localparam logic [2:0] ST_ANSWERED = 3'd0;
  localparam logic [2:0] ST_KEPT     = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // request command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // one stored line, tag marks the line of the current insert
  typedef struct packed {
    logic               tag;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
  } line_t;

  // what every cell of a chain does this cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHL,   // take right neighbor, last cell takes cell 0 (ring / pop)
    OP_SHR    // take left neighbor, cell 0 takes the pushed line
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    line_t    push;
  } chain_ctl_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_EVAL,
    S_INS_ACT,
    S_QRY,
    S_DONE
  } state_t;

endpackage

FILE: design/dlh_in_if.sv
// ----------------------------------------------------------------------------
// dlh_in_if
// Request channel: command plus line or abscissa, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dlh_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] slope;
  logic signed [31:0] intercept;
  logic signed [31:0] query_x;

  modport source (output valid, output cmd, output slope, output intercept,
                  output query_x, input ready);
  modport sink (input valid, input cmd, input slope, input intercept,
                input query_x, output ready);
endinterface

FILE: design/dlh_out_if.sv
// ----------------------------------------------------------------------------
// dlh_out_if
// Result channel: envelope value and status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dlh_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] hull_value;
  logic        [2:0]  status;

  modport source (output valid, output hull_value, output status, input ready);
  modport sink (input valid, input hull_value, input status, output ready);
endinterface

FILE: design/dynamic_line_hull_max_query.sv
// Insert: each step of the rebuild pass is a product state and a decide state
//   (S_INS_EVAL, S_INS_ACT) of the redundancy test.
// Query: one full ring rotation past one multiplier.
// One request at a time; ready returns in the cycle after the result register loads.
// Synchronous active-low reset empties the table (line count zero).
// ----------------------------------------------------------------------------
// dynamic_line_hull_max_query
// Upper envelope of lines kept in two cell chains: the source ring is rotated
// through a hull builder that pushes and pops the other chain as a stack.
// ----------------------------------------------------------------------------
module dynamic_line_hull_max_query #(
  parameter int MAX_LINES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dlh_in_if.sink    in_ch,
  dlh_out_if.source out_ch
);
  import dlh_pkg::*;

  localparam int DEPTH = MAX_LINES + 1;
  localparam int RW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(MAX_LINES + 1);

  state_t state_r, state_nxt;

  logic          sel_r, sel_nxt;        // which chain is the source
  logic          dir_r, dir_nxt;        // source slopes decrease along cells
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [RW-1:0] rot_r, rot_nxt;
  logic [RW-1:0] dsz_r, dsz_nxt;
  logic          pending_r, pending_nxt;
  logic          new_in_r, new_in_nxt;
  logic          eqdrop_r, eqdrop_nxt;
  logic          repl_r, repl_nxt;
  logic          have_r, have_nxt;
  logic          qvv_r, qvv_nxt;

  logic signed [31:0] new_m_r, new_m_nxt;
  logic signed [31:0] new_p_r, new_p_nxt;
  logic signed [31:0] qx_r, qx_nxt;
  logic signed [63:0] qv_r, qv_nxt;
  logic signed [63:0] best_r, best_nxt;
  logic signed [65:0] pl_r, pl_nxt;
  logic signed [65:0] pr_r, pr_nxt;
  logic signed [63:0] res_val_r, res_val_nxt;
  logic        [2:0]  res_st_r, res_st_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [63:0] out_val_r, out_val_nxt;
  logic        [2:0]  out_st_r, out_st_nxt;

  chain_ctl_t a_ctl, b_ctl;
  line_t      a_h0, a_h1, b_h0, b_h1;
  line_t      src_h0, dst_h0, dst_h1;
  cell_op_t   src_op, dst_op;
  line_t      dst_push;

  // chains
  dlh_chain #(.DEPTH(DEPTH)) u_chain_a (
    .clk(clk), .ctl(a_ctl), .head0(a_h0), .head1(a_h1)
  );
  dlh_chain #(.DEPTH(DEPTH)) u_chain_b (
    .clk(clk), .ctl(b_ctl), .head0(b_h0), .head1(b_h1)
  );

  assign src_h0 = sel_r ? b_h0 : a_h0;
  assign dst_h0 = sel_r ? a_h0 : b_h0;
  assign dst_h1 = sel_r ? a_h1 : b_h1;
  assign a_ctl  = sel_r ? chain_ctl_t'{op: dst_op, push: dst_push}
                        : chain_ctl_t'{op: src_op, push: dst_push};
  assign b_ctl  = sel_r ? chain_ctl_t'{op: src_op, push: dst_push}
                        : chain_ctl_t'{op: dst_op, push: dst_push};

  // merge decisions
  logic  head_live, go_now, eq_hit, use_new, cand_ok, fin, red, big_enough;
  line_t cand, ra, rb, rc;
  logic signed [32:0] d1, d2, d3, d4;

  assign head_live  = (rot_r < RW'(cnt_r));
  assign go_now     = !head_live || (dir_r ? (src_h0.slope < new_m_r)
                                           : (src_h0.slope > new_m_r));
  assign eq_hit     = pending_r && head_live && (src_h0.slope == new_m_r);
  assign use_new    = pending_r && go_now;
  assign cand_ok    = use_new || head_live;
  assign fin        = !pending_r && (rot_r == RW'(DEPTH));
  assign big_enough = (dsz_r >= RW'(2));
  assign red        = (pl_r >= pr_r);

  always_comb begin
    cand = use_new ? line_t'{tag: 1'b1, slope: new_m_r, intercept: new_p_r}
                   : line_t'{tag: 1'b0, slope: src_h0.slope, intercept: src_h0.intercept};
  end

  // redundancy operands in slope order a < b < c
  always_comb begin
    rb = dst_h0;
    ra = dir_r ? cand : dst_h1;
    rc = dir_r ? dst_h1 : cand;
    d1 = $signed({rc.intercept[31], rc.intercept}) - $signed({rb.intercept[31], rb.intercept});
    d2 = $signed({rb.slope[31], rb.slope}) - $signed({ra.slope[31], ra.slope});
    d3 = $signed({ra.intercept[31], ra.intercept}) - $signed({rb.intercept[31], rb.intercept});
    d4 = $signed({rb.slope[31], rb.slope}) - $signed({rc.slope[31], rc.slope});
  end

  // query term
  logic signed [63:0] q_prod, q_pext;
  assign q_prod = 64'(src_h0.slope) * 64'(qx_r);
  assign q_pext = $signed({{32{src_h0.intercept[31]}}, src_h0.intercept}) <<< FRAC_BITS;

  // finish status of an insert
  logic [2:0] ins_st;
  logic       commit;
  always_comb begin
    if (eqdrop_r || !new_in_r) begin
      ins_st = ST_DROPPED;
    end else if ((cnt_r == CW'(MAX_LINES)) && !repl_r) begin
      ins_st = ST_FULL;
    end else begin
      ins_st = ST_KEPT;
    end
    commit = repl_r || (ins_st == ST_KEPT);
  end

  logic in_acc;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.hull_value = out_val_r;
  assign out_ch.status     = out_st_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == CMD_INSERT) begin
            state_nxt = S_INS_EVAL;
          end else if (cnt_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_QRY;
          end
        end
      end
      S_INS_EVAL: state_nxt = S_INS_ACT;
      S_INS_ACT: begin
        state_nxt = fin ? S_DONE : S_INS_EVAL;
      end
      S_QRY: begin
        if (rot_r == RW'(DEPTH)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and chain controls
  always_comb begin
    sel_nxt = sel_r;  dir_nxt = dir_r;  cnt_nxt = cnt_r;  rot_nxt = rot_r;
    dsz_nxt = dsz_r;  pending_nxt = pending_r;  new_in_nxt = new_in_r;
    eqdrop_nxt = eqdrop_r;  repl_nxt = repl_r;  have_nxt = have_r;  qvv_nxt = qvv_r;
    new_m_nxt = new_m_r;  new_p_nxt = new_p_r;  qx_nxt = qx_r;  qv_nxt = qv_r;
    best_nxt = best_r;  pl_nxt = pl_r;  pr_nxt = pr_r;
    res_val_nxt = res_val_r;  res_st_nxt = res_st_r;
    out_valid_nxt = out_valid_r;  out_val_nxt = out_val_r;  out_st_nxt = out_st_r;
    src_op = OP_HOLD;  dst_op = OP_HOLD;
    dst_push = '{tag: cand.tag, slope: cand.slope, intercept: cand.intercept};

    // result register drains independently
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          new_m_nxt = in_ch.slope;
          new_p_nxt = in_ch.intercept;
          qx_nxt    = in_ch.query_x;
          rot_nxt   = '0;
          dsz_nxt   = '0;
          pending_nxt = 1'b1;
          new_in_nxt  = 1'b0;
          eqdrop_nxt  = 1'b0;
          repl_nxt    = 1'b0;
          have_nxt    = 1'b0;
          qvv_nxt     = 1'b0;
          res_val_nxt = '0;
          res_st_nxt  = ST_EMPTY;
        end
      end
      S_INS_EVAL: begin
        pl_nxt = 66'(d1) * 66'(d2);
        pr_nxt = 66'(d3) * 66'(d4);
      end
      S_INS_ACT: begin
        if (fin) begin
          res_val_nxt = '0;
          res_st_nxt  = ins_st;
          if (commit) begin
            sel_nxt = !sel_r;
            dir_nxt = !dir_r;
            cnt_nxt = CW'(dsz_r);
          end
        end else if (eq_hit) begin
          // same slope: keep the higher intercept
          if (src_h0.intercept >= new_p_r) begin
            eqdrop_nxt  = 1'b1;
            pending_nxt = 1'b0;
          end else begin
            repl_nxt = 1'b1;
            src_op   = OP_SHL;
            rot_nxt  = rot_r + RW'(1);
          end
        end else if (!cand_ok) begin
          // empty cell, just turn the ring
          src_op  = OP_SHL;
          rot_nxt = rot_r + RW'(1);
        end else if (big_enough && red) begin
          // top of hull stack is redundant
          dst_op  = OP_SHL;
          dsz_nxt = dsz_r - RW'(1);
          if (dst_h0.tag) new_in_nxt = 1'b0;
        end else begin
          dst_op  = OP_SHR;
          dsz_nxt = dsz_r + RW'(1);
          if (use_new) begin
            pending_nxt = 1'b0;
            new_in_nxt  = 1'b1;
          end else begin
            src_op  = OP_SHL;
            rot_nxt = rot_r + RW'(1);
          end
        end
      end
      S_QRY: begin
        if (qvv_r && (!have_r || (qv_r > best_r))) begin
          best_nxt = qv_r;
          have_nxt = 1'b1;
        end
        if (rot_r != RW'(DEPTH)) begin
          src_op  = OP_SHL;
          qv_nxt  = q_prod + q_pext;
          qvv_nxt = head_live;
          rot_nxt = rot_r + RW'(1);
        end else begin
          res_val_nxt = best_nxt;
          res_st_nxt  = ST_ANSWERED;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b0;
      dir_r       <= 1'b0;
      cnt_r       <= '0;
      rot_r       <= '0;
      dsz_r       <= '0;
      pending_r   <= 1'b0;
      new_in_r    <= 1'b0;
      eqdrop_r    <= 1'b0;
      repl_r      <= 1'b0;
      have_r      <= 1'b0;
      qvv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      dir_r       <= dir_nxt;
      cnt_r       <= cnt_nxt;
      rot_r       <= rot_nxt;
      dsz_r       <= dsz_nxt;
      pending_r   <= pending_nxt;
      new_in_r    <= new_in_nxt;
      eqdrop_r    <= eqdrop_nxt;
      repl_r      <= repl_nxt;
      have_r      <= have_nxt;
      qvv_r       <= qvv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    new_m_r   <= new_m_nxt;
    new_p_r   <= new_p_nxt;
    qx_r      <= qx_nxt;
    qv_r      <= qv_nxt;
    best_r    <= best_nxt;
    pl_r      <= pl_nxt;
    pr_r      <= pr_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
  end
endmodule

FILE: design/dlh_cell.sv
// ----------------------------------------------------------------------------
// dlh_cell
// One storage cell of a line chain: holds a line or takes it from a neighbor.
// ----------------------------------------------------------------------------
module dlh_cell (
  input  logic               clk,
  input  dlh_pkg::cell_op_t  op,
  input  dlh_pkg::line_t     from_left,
  input  dlh_pkg::line_t     from_right,
  output dlh_pkg::line_t     q
);
  import dlh_pkg::*;

  line_t data_r;
  line_t data_nxt;

  // neighbor select
  always_comb begin
    unique case (op)
      OP_SHL:  data_nxt = from_right;
      OP_SHR:  data_nxt = from_left;
      default: data_nxt = data_r;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;
endmodule

FILE: design/dlh_chain.sv
// ----------------------------------------------------------------------------
// dlh_chain
// Row of line cells wired as a ring / push-down stack, head at cell 0.
// ----------------------------------------------------------------------------
module dlh_chain #(
  parameter int DEPTH = 65
) (
  input  logic                 clk,
  input  dlh_pkg::chain_ctl_t  ctl,
  output dlh_pkg::line_t       head0,
  output dlh_pkg::line_t       head1
);
  import dlh_pkg::*;

  line_t cell_q [DEPTH];

  // cell row, last cell wraps to cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    line_t left_in;
    line_t right_in;
    if (i == 0) begin : g_first
      assign left_in = ctl.push;
    end else begin : g_mid
      assign left_in = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = cell_q[0];
    end else begin : g_inner
      assign right_in = cell_q[i+1];
    end
    dlh_cell u_cell (
      .clk        (clk),
      .op         (ctl.op),
      .from_left  (left_in),
      .from_right (right_in),
      .q          (cell_q[i])
    );
  end

  assign head0 = cell_q[0];
  assign head1 = cell_q[1];
endmodule

FILE: design/dlh_checker.sv
// ----------------------------------------------------------------------------
// dlh_checker
// Port-level checks of the result channel of the line hull table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] hull_value,
  input logic [2:0]  status
);
  import dlh_pkg::*;

  // stalled result stays offered
  `DLH_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  // stalled result keeps its payload
  `DLH_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(hull_value) && $stable(status))
  // only defined status codes leave the block
  `DLH_ASSERT_NEVER(a_status_code, clk, rst_n, out_valid && (status > ST_EMPTY))
  // value is zero unless a query was answered
  `DLH_ASSERT_NEVER(a_value_zero, clk, rst_n, out_valid && (status != ST_ANSWERED) && (hull_value != 64'd0))
endmodule

bind dynamic_line_hull_max_query dlh_checker u_dlh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .hull_value (out_ch.hull_value),
  .status     (out_ch.status)
);
